/* design/slsm_pkg.sv */
// Shared constants, codes and the digit-root gap table of the skip-letter sequence matcher.
`default_nettype none

package slsm_pkg;

    localparam int TEXT_DEPTH_DEF   = 65536;
    localparam int MAX_WORDS_DEF    = 16;
    localparam int MAX_WORD_LEN_DEF = 16;

    localparam int TABLE_ROWS   = 8;
    localparam int TABLE_COLS   = 24;
    localparam int DECIMAL_BASE = 10;
    localparam int RESULT_CAP   = 16;

    // operation codes
    localparam logic [1:0] OP_TEXT  = 2'd0;
    localparam logic [1:0] OP_WORD  = 2'd1;
    localparam logic [1:0] OP_PROBE = 2'd2;

    // search types; anything else runs as the table mode
    localparam logic [1:0] MODE_EQUAL = 2'd0;
    localparam logic [1:0] MODE_FIB   = 2'd1;

    // configuration register indexes
    localparam logic [3:0] REG_SKIP      = 4'd0;
    localparam logic [3:0] REG_TYPE      = 4'd1;
    localparam logic [3:0] REG_LAST_POS  = 4'd2;
    localparam logic [3:0] REG_WORD_CNT  = 4'd3;

    typedef logic [TABLE_ROWS-1:0][TABLE_COLS-1:0][3:0] dr_table_t;

    function automatic int digit_root(input int v);
        int r;
        r = v;
        while (r >= DECIMAL_BASE)
            r = r / DECIMAL_BASE + r % DECIMAL_BASE;
        return r;
    endfunction

    function automatic dr_table_t build_dr_table();
        dr_table_t t;
        int a;
        int b;
        int c;
        t = '0;
        for (int row = 0; row < TABLE_ROWS; row++) begin
            a = 1;
            b = 1;
            c = 2;
            for (int col = 0; col < TABLE_COLS; col++) begin
                t[row][col] = 4'(digit_root(digit_root(a) * (row + 1)));
                a = b;
                b = c;
                c = a + b;
            end
        end
        return t;
    endfunction

    localparam dr_table_t DR_TABLE = build_dr_table();

endpackage

`default_nettype wire

/* design/skip_letter_sequence_matcher.sv */
// Top level of the skip-letter sequence matcher: letter stores, probe sequencer, result stage.
`default_nettype none

// Write items (text letter, word letter) are taken while the block is idle. A
// probe walks the word slots in order; each slot of two or more letters is
// walked letter by letter, with one text-memory read per letter setting the
// pace, then checked and decided, while an unused or too-short slot is skipped.
// A probe also waits on the result port while a result beat is stalled. Results
// come one beat per match in ascending slot order, last marks the final one.
// TEXT_DEPTH must be a power of two; text addresses wrap at that depth.
module skip_letter_sequence_matcher #(
    parameter int TEXT_DEPTH   = slsm_pkg::TEXT_DEPTH_DEF,
    parameter int MAX_WORDS    = slsm_pkg::MAX_WORDS_DEF,
    parameter int MAX_WORD_LEN = slsm_pkg::MAX_WORD_LEN_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  operation,
    input  wire logic [15:0] position,
    input  wire logic [7:0]  letter,
    input  wire logic [3:0]  word_slot,
    input  wire logic [3:0]  letter_index,
    input  wire logic [4:0]  word_length,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [3:0]       matched_slot,
    output logic             reversed,
    output logic [15:0]      first_position,
    output logic [15:0]      middle_position,
    output logic [15:0]      end_position,
    output logic             last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [3:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int TA = $clog2(TEXT_DEPTH);
    localparam int WD = MAX_WORDS * MAX_WORD_LEN;
    localparam int WA = (WD > 1) ? $clog2(WD) : 1;
    localparam int SA = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int SW = $clog2(MAX_WORDS + 1);
    localparam int IW = $clog2(MAX_WORD_LEN + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOAD   = 3'd1;
    localparam logic [2:0] ST_RUN    = 3'd2;
    localparam logic [2:0] ST_CHECK  = 3'd3;
    localparam logic [2:0] ST_DECIDE = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    localparam logic [16:0] POS_OVER = 17'h10000;

    // stores
    logic [7:0] text_mem [TEXT_DEPTH];
    logic [7:0] word_mem [WD];
    logic [4:0] len_mem  [MAX_WORDS];

    logic [7:0] text_rd_reg;
    logic [7:0] wf_rd_reg;
    logic [7:0] wr_rd_reg;

    // configuration
    logic [15:0] skip_reg,     skip_next;
    logic [1:0]  type_reg,     type_next;
    logic [15:0] lastpos_reg,  lastpos_next;
    logic [4:0]  wcount_reg,   wcount_next;

    // sequencer
    logic [2:0]    state_reg,  state_next;
    logic [SW-1:0] s_reg,      s_next;
    logic [4:0]    n_reg,      n_next;
    logic [IW-1:0] i_reg,      i_next;
    logic [4:0]    len_reg,    len_next;
    logic [16:0]   p_reg,      p_next;
    logic [16:0]   fa_reg,     fa_next;
    logic [16:0]   fb_reg,     fb_next;
    logic          fwd_reg,    fwd_next;
    logic          rev_reg,    rev_next;
    logic          cmp_reg,    cmp_next;
    logic [15:0]   start_reg,  start_next;
    logic [15:0]   first_reg,  first_next;
    logic [15:0]   mid_reg,    mid_next;
    logic [15:0]   end_reg,    end_next;

    // held match waiting to learn whether it is the final one
    logic          pend_valid_reg, pend_valid_next;
    logic [3:0]    pend_slot_reg,  pend_slot_next;
    logic          pend_rev_reg,   pend_rev_next;
    logic [15:0]   pend_first_reg, pend_first_next;
    logic [15:0]   pend_mid_reg,   pend_mid_next;
    logic [15:0]   pend_end_reg,   pend_end_next;

    // result register
    logic          ov_reg,    ov_next;
    logic [3:0]    oslot_reg, oslot_next;
    logic          orev_reg,  orev_next;
    logic [15:0]   ofirst_reg, ofirst_next;
    logic [15:0]   omid_reg,  omid_next;
    logic [15:0]   oend_reg,  oend_next;
    logic          olast_reg, olast_next;

    logic          accept;
    logic          issue;
    logic          fail;
    logic          out_free;
    logic          slot_done;
    logic [TA-1:0] text_wr_addr;
    logic [TA-1:0] text_rd_addr;
    logic [TA+15:0] pos_ext;
    logic [TA+15:0] p_ext;
    logic [WA-1:0] word_wr_addr;
    logic [WA-1:0] wf_addr;
    logic [WA-1:0] wr_addr;
    logic [SA-1:0] s_idx;
    logic          word_wr;
    logic [4:0]    len_clamped;
    logic [4:0]    mid_idx;
    logic [4:0]    i_ext;
    logic [2:0]    row;
    logic [15:0]   skip_m1;
    logic [31:0]   fib_prod;
    logic [33:0]   gap;
    logic [33:0]   sum;
    logic [4:0]    cur_len;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !ov_reg || !out_stall;

    assign pos_ext      = {{TA{1'b0}}, position};
    assign p_ext        = {{TA{1'b0}}, p_reg[15:0]};
    assign text_wr_addr = pos_ext[TA-1:0];
    assign text_rd_addr = p_ext[TA-1:0];

    assign s_idx        = s_reg[SA-1:0];
    assign i_ext        = 5'(i_reg);
    assign word_wr      = accept && (operation == slsm_pkg::OP_WORD)
                          && (int'(word_slot) < MAX_WORDS);
    assign word_wr_addr = WA'(int'(word_slot) * MAX_WORD_LEN + int'(letter_index));
    assign wf_addr      = WA'(int'(s_idx) * MAX_WORD_LEN + int'(i_reg));
    assign wr_addr      = WA'(int'(s_idx) * MAX_WORD_LEN + int'(len_reg) - 1 - int'(i_reg));
    assign len_clamped  = (int'(word_length) > MAX_WORD_LEN) ? 5'(MAX_WORD_LEN) : word_length;
    assign mid_idx      = (len_reg - 5'd1) >> 1;
    assign cur_len      = len_mem[s_idx];

    assign issue = (state_reg == ST_RUN) && (p_reg <= {1'b0, lastpos_reg});
    assign fail  = (state_reg == ST_RUN) && (p_reg > {1'b0, lastpos_reg});

    // gap after letter i
    assign skip_m1  = skip_reg - 16'd1;
    assign row      = skip_m1[2:0];
    assign fib_prod = fa_reg[15:0] * skip_reg;
    always_comb
    begin
        unique case (type_reg)
            slsm_pkg::MODE_EQUAL: gap = 34'(skip_reg) + 34'd1;
            slsm_pkg::MODE_FIB:   gap = 34'(fib_prod) + 34'd1;
            default:              gap = 34'(slsm_pkg::DR_TABLE[row][i_ext]) + 34'd1;
        endcase
    end
    assign sum = 34'(p_reg) + gap;

    // text memory
    always_ff @(posedge clk)
    begin
        if (accept && operation == slsm_pkg::OP_TEXT)
            text_mem[text_wr_addr] <= letter;
        if (issue)
            text_rd_reg <= text_mem[text_rd_addr];
    end

    // word letter memory, two read ports
    always_ff @(posedge clk)
    begin
        if (word_wr && int'(letter_index) < MAX_WORD_LEN)
            word_mem[word_wr_addr] <= letter;
        if (issue)
        begin
            wf_rd_reg <= word_mem[wf_addr];
            wr_rd_reg <= word_mem[wr_addr];
        end
    end

    // word lengths
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_WORDS; k++)
                len_mem[k] <= 5'd0;
        end
        else if (word_wr)
        begin
            len_mem[SA'(word_slot)] <= len_clamped;
        end
    end

    always_comb
    begin
        skip_next       = skip_reg;
        type_next       = type_reg;
        lastpos_next    = lastpos_reg;
        wcount_next     = wcount_reg;
        state_next      = state_reg;
        s_next          = s_reg;
        n_next          = n_reg;
        i_next          = i_reg;
        len_next        = len_reg;
        p_next          = p_reg;
        fa_next         = fa_reg;
        fb_next         = fb_reg;
        fwd_next        = fwd_reg;
        rev_next        = rev_reg;
        cmp_next        = issue;
        start_next      = start_reg;
        first_next      = first_reg;
        mid_next        = mid_reg;
        end_next        = end_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        pend_rev_next   = pend_rev_reg;
        pend_first_next = pend_first_reg;
        pend_mid_next   = pend_mid_reg;
        pend_end_next   = pend_end_reg;
        ov_next         = ov_reg;
        oslot_next      = oslot_reg;
        orev_next       = orev_reg;
        ofirst_next     = ofirst_reg;
        omid_next       = omid_reg;
        oend_next       = oend_reg;
        olast_next      = olast_reg;
        slot_done       = 1'b0;

        if (ov_reg && !out_stall)
            ov_next = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                slsm_pkg::REG_SKIP:     skip_next    = cfg_data;
                slsm_pkg::REG_TYPE:     type_next    = cfg_data[1:0];
                slsm_pkg::REG_LAST_POS: lastpos_next = cfg_data;
                slsm_pkg::REG_WORD_CNT: wcount_next  = cfg_data[4:0];
                default:                ;
            endcase
        end

        // fold the letter read last cycle into the match flags
        if (cmp_reg)
        begin
            fwd_next = fwd_reg && (text_rd_reg == wf_rd_reg);
            rev_next = rev_reg && (text_rd_reg == wr_rd_reg);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && operation == slsm_pkg::OP_PROBE)
                begin
                    start_next = position;
                    s_next     = '0;
                    n_next     = 5'd0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (int'(s_reg) >= int'(wcount_reg) || int'(s_reg) >= MAX_WORDS
                    || int'(n_reg) >= slsm_pkg::RESULT_CAP)
                begin
                    state_next = ST_FINISH;
                end
                else if (cur_len < 5'd2)
                begin
                    s_next = s_reg + 1'b1;
                end
                else
                begin
                    len_next   = cur_len;
                    i_next     = '0;
                    p_next     = {1'b0, start_reg};
                    fa_next    = 17'd1;
                    fb_next    = 17'd1;
                    fwd_next   = 1'b1;
                    rev_next   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (fail)
                begin
                    slot_done = 1'b1;
                end
                else
                begin
                    if (i_ext == 5'd0)
                        first_next = p_reg[15:0];
                    if (i_ext == mid_idx)
                        mid_next = p_reg[15:0];
                    if (i_ext == len_reg - 5'd1)
                    begin
                        end_next   = p_reg[15:0];
                        state_next = ST_CHECK;
                    end
                    p_next  = (sum > 34'hFFFF) ? POS_OVER : sum[16:0];
                    fa_next = fb_reg;
                    fb_next = fa_reg + fb_reg;
                    i_next  = i_reg + 1'b1;
                end
            end
            ST_CHECK:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (!fwd_reg && !rev_reg)
                begin
                    slot_done = 1'b1;
                end
                else if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        ov_next     = 1'b1;
                        oslot_next  = pend_slot_reg;
                        orev_next   = pend_rev_reg;
                        ofirst_next = pend_first_reg;
                        omid_next   = pend_mid_reg;
                        oend_next   = pend_end_reg;
                        olast_next  = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_slot_next  = 4'(s_reg);
                    pend_rev_next   = !fwd_reg;
                    pend_first_next = first_reg;
                    pend_mid_next   = mid_reg;
                    pend_end_next   = end_reg;
                    n_next          = n_reg + 5'd1;
                    slot_done       = 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    ov_next         = 1'b1;
                    oslot_next      = pend_slot_reg;
                    orev_next       = pend_rev_reg;
                    ofirst_next     = pend_first_reg;
                    omid_next       = pend_mid_reg;
                    oend_next       = pend_end_reg;
                    olast_next      = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (slot_done)
        begin
            s_next     = s_reg + 1'b1;
            state_next = ST_LOAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg       <= 16'd1;
            type_reg       <= slsm_pkg::MODE_EQUAL;
            lastpos_reg    <= 16'hFFFF;
            wcount_reg     <= 5'd0;
            state_reg      <= ST_IDLE;
            s_reg          <= '0;
            n_reg          <= 5'd0;
            i_reg          <= '0;
            len_reg        <= 5'd0;
            p_reg          <= 17'd0;
            fa_reg         <= 17'd1;
            fb_reg         <= 17'd1;
            fwd_reg        <= 1'b0;
            rev_reg        <= 1'b0;
            cmp_reg        <= 1'b0;
            start_reg      <= 16'd0;
            first_reg      <= 16'd0;
            mid_reg        <= 16'd0;
            end_reg        <= 16'd0;
            pend_valid_reg <= 1'b0;
            pend_slot_reg  <= 4'd0;
            pend_rev_reg   <= 1'b0;
            pend_first_reg <= 16'd0;
            pend_mid_reg   <= 16'd0;
            pend_end_reg   <= 16'd0;
            ov_reg         <= 1'b0;
            oslot_reg      <= 4'd0;
            orev_reg       <= 1'b0;
            ofirst_reg     <= 16'd0;
            omid_reg       <= 16'd0;
            oend_reg       <= 16'd0;
            olast_reg      <= 1'b0;
        end
        else
        begin
            skip_reg       <= skip_next;
            type_reg       <= type_next;
            lastpos_reg    <= lastpos_next;
            wcount_reg     <= wcount_next;
            state_reg      <= state_next;
            s_reg          <= s_next;
            n_reg          <= n_next;
            i_reg          <= i_next;
            len_reg        <= len_next;
            p_reg          <= p_next;
            fa_reg         <= fa_next;
            fb_reg         <= fb_next;
            fwd_reg        <= fwd_next;
            rev_reg        <= rev_next;
            cmp_reg        <= cmp_next;
            start_reg      <= start_next;
            first_reg      <= first_next;
            mid_reg        <= mid_next;
            end_reg        <= end_next;
            pend_valid_reg <= pend_valid_next;
            pend_slot_reg  <= pend_slot_next;
            pend_rev_reg   <= pend_rev_next;
            pend_first_reg <= pend_first_next;
            pend_mid_reg   <= pend_mid_next;
            pend_end_reg   <= pend_end_next;
            ov_reg         <= ov_next;
            oslot_reg      <= oslot_next;
            orev_reg       <= orev_next;
            ofirst_reg     <= ofirst_next;
            omid_reg       <= omid_next;
            oend_reg       <= oend_next;
            olast_reg      <= olast_next;
        end
    end

    assign out_valid       = ov_reg;
    assign matched_slot    = oslot_reg;
    assign reversed        = orev_reg;
    assign first_position  = ofirst_reg;
    assign middle_position = omid_reg;
    assign end_position    = oend_reg;
    assign last            = olast_reg;

endmodule

`default_nettype wire

/* design/slsm_checker.sv */
// Port-level checks of the skip-letter sequence matcher, bound to the top level.
`default_nettype none

module slsm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic [1:0]  operation,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic        last,
    input wire logic [15:0] first_position,
    input wire logic [15:0] end_position
);

    // a held result beat keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(first_position)
                                   && $stable(end_position))
        else $error("result beat changed while stalled");

    // no item yields a result in the cycle right after it is taken
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_valid |=> !out_valid)
        else $error("result appeared one cycle after an input beat");

    // final beat taken while the block is idle: nothing follows right away
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last && !out_stall && !in_stall |=> !out_valid)
        else $error("result beat after the final one");

    // gathered letters run forward in the text
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> end_position > first_position)
        else $error("end position not past first position");

    // writes are always taken at once when the block is free
    a_write_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && operation != slsm_pkg::OP_PROBE |=> !in_stall)
        else $error("block busy after a write beat");

endmodule

bind skip_letter_sequence_matcher slsm_checker u_slsm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .operation      (operation),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .last           (last),
    .first_position (first_position),
    .end_position   (end_position)
);

`default_nettype wire

/* tb/tb_skip_letter_sequence_matcher.sv */
// Self-checking testbench for the skip-letter sequence matcher: directed and random loads and probes.
`default_nettype none

module tb_skip_letter_sequence_matcher;
    import slsm_pkg::*;

    localparam int LIMIT  = 2000000;
    localparam int DRAIN  = 400;
    localparam int NWORDS = 16;
    localparam int WLEN   = 16;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] pos;
        logic [7:0]  ch;
        logic [3:0]  slot;
        logic [3:0]  idx;
        logic [4:0]  len;
    } load_t;

    typedef struct packed {
        logic [3:0]  slot;
        logic        rev;
        logic [15:0] first;
        logic [15:0] mid;
        logic [15:0] tail;
        logic        fin;
    } hit_t;

    class match_board;
        bit [7:0]    text[65536];
        bit          text_ok[65536];
        bit [7:0]    word[NWORDS][WLEN];
        bit          word_ok[NWORDS][WLEN];
        int unsigned lens[NWORDS];
        int unsigned skip_dist = 1;
        int unsigned mode = 0;
        int unsigned last_pos = 65535;
        int unsigned count = 0;
        hit_t        hits_due[$];
        int          fails = 0;

        function int unsigned droot(int unsigned v);
            while (v >= 10)
                v = v / 10 + v % 10;
            return v;
        endfunction

        function longint unsigned gap(int i);
            longint unsigned a, b, c;
            int j;
            int unsigned row;
            a = 1;
            b = 1;
            c = 2;
            if (mode == MODE_EQUAL)
                return 1 + longint'(skip_dist);
            if (mode == MODE_FIB) begin
                for (j = 0; j < i; j++) begin
                    a = b;
                    b = c;
                    c = a + b;
                end
                return 1 + a * skip_dist;
            end
            row = ((skip_dist - 1) & 16'hFFFF) % 8;
            for (j = 0; j < i % 24; j++) begin
                a = b;
                b = c;
                c = a + b;
            end
            return 1 + droot(droot(int'(a)) * (row + 1));
        endfunction

        function int used();
            return (count < NWORDS) ? count : NWORDS;
        endfunction

        // positions gathered for slot s from p; returns 0 when the word runs past last_pos
        function bit span(int s, int unsigned p, output longint unsigned at[WLEN]);
            longint unsigned q;
            int i;
            q = p;
            for (i = 0; i < WLEN; i++)
                at[i] = 0;
            for (i = 0; i < lens[s]; i++) begin
                if (q > last_pos)
                    return 0;
                at[i] = q;
                q += gap(i);
            end
            return 1;
        endfunction

        function void set_reg(logic [3:0] idx, logic [15:0] d);
            case (idx)
                REG_SKIP:     skip_dist = d;
                REG_TYPE:     mode = d[1:0];
                REG_LAST_POS: last_pos = d;
                REG_WORD_CNT: count = d[4:0];
                default: ;
            endcase
        endfunction

        function void note(load_t it);
            longint unsigned at[WLEN];
            int s, i, n, l;
            bit fw, rv;
            hit_t h;
            n = 0;
            case (it.op)
                OP_TEXT:
                begin
                    text[it.pos] = it.ch;
                    text_ok[it.pos] = 1;
                end
                OP_WORD:
                begin
                    lens[it.slot] = (it.len > WLEN) ? WLEN : it.len;
                    word[it.slot][it.idx] = it.ch;
                    word_ok[it.slot][it.idx] = 1;
                end
                OP_PROBE:
                begin
                    for (s = 0; s < used(); s++) begin
                        l = lens[s];
                        if (l < 2 || !span(s, it.pos, at))
                            continue;
                        fw = 1;
                        rv = 1;
                        for (i = 0; i < l; i++) begin
                            if (text[at[i][15:0]] != word[s][i])
                                fw = 0;
                            if (text[at[i][15:0]] != word[s][l-1-i])
                                rv = 0;
                        end
                        if (!fw && !rv)
                            continue;
                        h.slot  = s;
                        h.rev   = !fw;
                        h.first = at[0][15:0];
                        h.mid   = at[(l-1)/2][15:0];
                        h.tail  = at[l-1][15:0];
                        h.fin   = 0;
                        hits_due.push_back(h);
                        n++;
                    end
                    if (n > 0)
                        hits_due[$].fin = 1;
                end
                default: ;
            endcase
        endfunction

        function void check(hit_t got);
            hit_t e;
            if (hits_due.size() == 0) begin
                $error("unexpected result beat slot=%0d", got.slot);
                fails++;
                return;
            end
            e = hits_due.pop_front();
            if (got.slot !== e.slot) begin
                $error("matched_slot exp %0d got %0d", e.slot, got.slot);
                fails++;
            end
            if (got.rev !== e.rev) begin
                $error("reversed exp %0d got %0d", e.rev, got.rev);
                fails++;
            end
            if (got.first !== e.first) begin
                $error("first_position exp %0d got %0d", e.first, got.first);
                fails++;
            end
            if (got.mid !== e.mid) begin
                $error("middle_position exp %0d got %0d", e.mid, got.mid);
                fails++;
            end
            if (got.tail !== e.tail) begin
                $error("end_position exp %0d got %0d", e.tail, got.tail);
                fails++;
            end
            if (got.fin !== e.fin) begin
                $error("last exp %0d got %0d", e.fin, got.fin);
                fails++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [1:0]  operation = '0;
    logic [15:0] position = '0;
    logic [7:0]  letter = '0;
    logic [3:0]  word_slot = '0;
    logic [3:0]  letter_index = '0;
    logic [4:0]  word_length = '0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [3:0]  matched_slot;
    logic        reversed;
    logic [15:0] first_position;
    logic [15:0] middle_position;
    logic [15:0] end_position;
    logic        last;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [3:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    match_board sb = new();
    int  cycles = 0;
    int  burst_left = 0;
    bit  no_gaps = 0;
    int  hold_asked = 0;
    int  hold_taken = 0;
    int  hold_cnt = 0;
    int  stall_pct = 0;

    skip_letter_sequence_matcher dut (.*);

    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb_skip_letter_sequence_matcher failed");
            $finish;
        end
    end

    // receiver: long hold on request, otherwise a stall density that drifts
    always @(posedge clk)
    begin
        if (cycles % 64 == 0)
            stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 85);
        if (hold_cnt == 0 && hold_taken < hold_asked) begin
            hold_taken++;
            hold_cnt = 800;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            out_stall <= 1;
        end else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check({matched_slot, reversed, first_position, middle_position,
                      end_position, last});
    end

    task automatic send(input logic [1:0] op, input logic [15:0] p, input logic [7:0] ch,
                        input logic [3:0] s, input logic [3:0] i, input logic [4:0] l);
        bit ok;
        int g;
        in_valid     <= 1;
        operation    <= op;
        position     <= p;
        letter       <= ch;
        word_slot    <= s;
        letter_index <= i;
        word_length  <= l;
        forever begin
            @(negedge clk);
            ok = !in_stall;
            @(posedge clk);
            if (ok)
                break;
        end
        sb.note({op, p, ch, s, i, l});
        if (!no_gaps) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (g > 0) begin
                    in_valid <= 0;
                    repeat (g) @(posedge clk);
                end
            end else
                burst_left--;
        end
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.hits_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [3:0] idx, input logic [15:0] d);
        bit ok;
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= d;
        forever begin
            @(negedge clk);
            ok = cfg_ready;
            @(posedge clk);
            if (ok)
                break;
        end
        sb.set_reg(idx, d);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    function automatic logic [7:0] pick_letter();
        return 8'h61 + $urandom_range(0, 1);
    endfunction

    task automatic load_word(input int s, input logic [4:0] lf);
        int l;
        l = (lf > WLEN) ? WLEN : lf;
        if (l == 0)
            send(OP_WORD, $urandom, pick_letter(), s, $urandom_range(0, 15), lf);
        for (int i = 0; i < l; i++)
            send(OP_WORD, $urandom, pick_letter(), s, i, lf);
    endtask

    // make sure every letter the probe reads is defined, optionally plant a word
    task automatic probe(input logic [15:0] p, input bit plant);
        longint unsigned at[WLEN];
        int s, l, cand[$];
        bit rv;
        for (s = 0; s < sb.used(); s++) begin
            l = sb.lens[s];
            if (l < 2)
                continue;
            for (int i = 0; i < l; i++)
                if (!sb.word_ok[s][i])
                    send(OP_WORD, $urandom, pick_letter(), s, i, l);
            if (sb.span(s, p, at))
                cand.push_back(s);
        end
        if (plant && cand.size() > 0) begin
            s = cand[$urandom_range(0, cand.size() - 1)];
            l = sb.lens[s];
            rv = $urandom_range(0, 1);
            void'(sb.span(s, p, at));
            for (int i = 0; i < l; i++)
                send(OP_TEXT, at[i][15:0], sb.word[s][rv ? l-1-i : i], $urandom, $urandom,
                     $urandom);
        end
        foreach (cand[k]) begin
            void'(sb.span(cand[k], p, at));
            for (int i = 0; i < sb.lens[cand[k]]; i++)
                if (!sb.text_ok[at[i][15:0]])
                    send(OP_TEXT, at[i][15:0], pick_letter(), $urandom, $urandom, $urandom);
        end
        send(OP_PROBE, p, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic random_traffic(input int n);
        int r;
        logic [4:0] lf;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 8)
                send(2'd3, $urandom, $urandom, $urandom, $urandom, $urandom);
            else if (r < 18)
                send(OP_TEXT, $urandom, $urandom, $urandom, $urandom, $urandom);
            else if (r < 26) begin
                r = $urandom_range(0, 9);
                lf = (r == 0) ? $urandom_range(0, 1) :
                     (r == 1) ? $urandom_range(16, 31) : $urandom_range(2, 5);
                load_word($urandom_range(0, 15), lf);
            end else
                probe((sb.last_pos < 60) ? $urandom_range(0, sb.last_pos) :
                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, sb.last_pos) :
                      $urandom_range(0, 50), $urandom_range(0, 9) < 7);
        end
    endtask

    initial
    begin
        logic [15:0] skp, lp;
        logic [1:0]  md;
        logic [4:0]  wc;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // after reset no slot is in use: the probe gives nothing
        send(OP_PROBE, 16'd0, 8'd0, 4'd0, 4'd0, 5'd0);
        drain();
        cfg_write(REG_WORD_CNT, 16'd4);
        send(OP_WORD, 16'hFFFF, 8'h00, 4'd0, 4'd0, 5'd2);
        send(OP_WORD, 16'h0000, 8'hFF, 4'd0, 4'd1, 5'd2);
        send(OP_WORD, 16'h0000, 8'h61, 4'd1, 4'd15, 5'd0);
        send(OP_WORD, 16'h0000, 8'h61, 4'd2, 4'd0, 5'd1);
        send(OP_WORD, 16'h0000, 8'h61, 4'd3, 4'd0, 5'd3);
        send(OP_WORD, 16'h0000, 8'h62, 4'd3, 4'd1, 5'd3);
        send(OP_WORD, 16'h0000, 8'h61, 4'd3, 4'd2, 5'd3);
        send(OP_TEXT, 16'd0, 8'h00, 4'hF, 4'hF, 5'h1F);
        send(OP_TEXT, 16'd2, 8'hFF, 4'hF, 4'hF, 5'h1F);
        send(OP_TEXT, 16'd4, 8'h61, 4'hF, 4'hF, 5'h1F);
        probe(16'd0, 0);
        send(OP_TEXT, 16'd0, 8'hFF, 4'h0, 4'h0, 5'h0);
        send(OP_TEXT, 16'd2, 8'h00, 4'h0, 4'h0, 5'h0);
        probe(16'd0, 0);
        probe(16'd3, 1);
        probe(16'hFFFF, 1);
        send(2'd3, 16'hFFFF, 8'hFF, 4'hF, 4'hF, 5'h1F);
        load_word(5, 5'd31);
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            case (ph)
                0: begin skp = 1;     md = MODE_EQUAL; lp = 16'hFFFF; wc = 16; end
                1: begin skp = 0;     md = MODE_EQUAL; lp = 16'hFFFF; wc = 16; end
                2: begin skp = 16'hFFFF; md = MODE_FIB; lp = 16'hFFFF; wc = 16; end
                3: begin skp = 2;     md = MODE_FIB;   lp = 16'hFFFF; wc = 8;  end
                4: begin skp = 3;     md = 2'd2;       lp = 16'hFFFF; wc = 16; end
                5: begin skp = 0;     md = 2'd3;       lp = 16'hFFFF; wc = 31; end
                6: begin skp = 1;     md = MODE_EQUAL; lp = 16'd0;    wc = 31; end
                7: begin skp = 5;     md = MODE_EQUAL; lp = 16'd40;   wc = 8;  end
                8: begin skp = 1;     md = MODE_EQUAL; lp = 16'hFFFF; wc = 16; end
                default:
                begin
                    skp = $urandom_range(0, 7);
                    md  = $urandom_range(0, 3);
                    lp  = ($urandom_range(0, 1) == 0) ? 16'hFFFF : $urandom_range(20, 400);
                    wc  = $urandom_range(0, 31);
                end
            endcase
            cfg_write(REG_SKIP, skp);
            cfg_write(REG_TYPE, md);
            cfg_write(REG_LAST_POS, lp);
            cfg_write(REG_WORD_CNT, wc);
            if (ph == 8) begin
                // short words everywhere so most slots hit; receiver blocks meanwhile
                for (int s = 0; s < NWORDS; s++)
                    load_word(s, 5'd2);
                hold_asked++;
                no_gaps = 1;
                for (int k = 0; k < 12; k++)
                    probe($urandom_range(0, 40), 1);
                no_gaps = 0;
            end else
                random_traffic(28);
            drain();
        end

        if (sb.fails == 0)
            $display("tb_skip_letter_sequence_matcher passed");
        else
            $display("tb_skip_letter_sequence_matcher failed");
        $finish;
    end

endmodule

`default_nettype wire
